FILE: hdl/hrtp_pkg.sv
package hrtp_pkg;

  localparam int PACKET_BYTES = 1200;
  localparam int HEADER_BYTES = 12;
  localparam int STORE_DEPTH  = 2048;
  localparam int DESC_BYTES   = 6;
  localparam int FU_CHUNK     = PACKET_BYTES - HEADER_BYTES - 2;
  localparam int BIG_LIMIT    = PACKET_BYTES - HEADER_BYTES;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int PRW = $clog2(PACKET_BYTES + 1);

  // A queued NALU takes at least two data bytes plus its descriptor.
  localparam int DESC_DEPTH = STORE_DEPTH / 8;
  localparam int DW         = $clog2(DESC_DEPTH);
  localparam int DCW        = $clog2(DESC_DEPTH + 1);

  localparam logic [7:0] FU_A_TYPE     = 8'd28;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] NRI_MASK      = 8'h60;
  localparam logic [7:0] FU_START      = 8'h80;
  localparam logic [7:0] FU_END        = 8'h40;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] count_t;
  typedef logic [DW-1:0] desc_idx_t;
  typedef logic [DCW-1:0] desc_cnt_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSH_OK = 2'd0,
    ST_BYTE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Where the outgoing byte comes from once the store read returns.
  typedef enum logic [1:0] {
    BK_DATA    = 2'd0,
    BK_IND_RAM = 2'd1,
    BK_IND_REG = 2'd2,
    BK_HDR     = 2'd3
  } byte_kind_t;

  typedef enum logic [1:0] {
    PH_IND  = 2'd0,
    PH_HDR  = 2'd1,
    PH_DATA = 2'd2
  } fu_phase_t;

  typedef struct packed {
    logic [31:0] stamp;
    count_t      len;
    logic        first;
    logic        last;
  } desc_t;

  typedef struct packed {
    status_t     status;
    byte_kind_t  kind;
    logic        pkt_start;
    logic        pkt_end;
    logic        fr_first;
    logic        fr_last;
    logic        fu_s;
    logic        fu_e;
    logic [31:0] ptime;
  } pull_info_t;

  function automatic addr_t addr_add(addr_t a, addr_t n);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, n};
    if (s >= (AW+1)'(STORE_DEPTH)) begin
      s = s - (AW+1)'(STORE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic addr_t addr_sub(addr_t a, addr_t n);
    logic [AW:0] s;
    if (a >= n) begin
      s = {1'b0, a} - {1'b0, n};
    end else begin
      s = {1'b0, a} + (AW+1)'(STORE_DEPTH) - {1'b0, n};
    end
    return s[AW-1:0];
  endfunction

endpackage

FILE: hdl/hrtp_ram.sv
module hrtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/hrtp_writer.sv
module hrtp_writer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_frame,
  input  logic [31:0]       timestamp,
  input  hrtp_pkg::count_t  take,
  output logic              reject,
  output logic              byte_we,
  output hrtp_pkg::addr_t   byte_waddr,
  output logic [7:0]        byte_wdata,
  output logic              desc_we,
  output hrtp_pkg::desc_idx_t desc_waddr,
  output hrtp_pkg::desc_t   desc_wdata
);
  import hrtp_pkg::*;

  addr_t       write_pointer, write_pointer_next;
  addr_t       nalu_base, nalu_base_next;
  count_t      stored_count, stored_count_next;
  count_t      nalu_len, nalu_len_next;
  logic [1:0]  zero_run, zero_run_next;
  logic        inside_nalu, inside_nalu_next;
  logic        first_nalu_pending, first_nalu_pending_next;
  logic        frame_open;
  logic [31:0] frame_time, frame_time_next;
  desc_idx_t   desc_wr_idx;

  logic        sc_hit, keep;
  count_t      len_a, len_b, trim, taken;
  logic [CW:0] freed, held;
  addr_t       wp_close;
  count_t      sc_close;

  always_comb begin
    sc_hit = (zero_run >= 2'd2) && (data_byte == 8'h01);
    len_a  = (nalu_len >= count_t'(2)) ? nalu_len - count_t'(2) : '0;
    len_b  = (len_a > count_t'(1) && zero_run == 2'd3) ? len_a - count_t'(1) : len_a;
    keep   = len_b > count_t'(1);
    trim   = nalu_len - len_b;
    if (!inside_nalu) begin
      freed = '0;
    end else if (keep) begin
      freed = {1'b0, trim};
    end else begin
      freed = {1'b0, nalu_len} + (CW+1)'(DESC_BYTES);
    end
    held = {1'b0, stored_count} - freed;
    if (sc_hit) begin
      reject = held > (CW+1)'(STORE_DEPTH - DESC_BYTES);
    end else begin
      reject = inside_nalu && (stored_count >= count_t'(STORE_DEPTH));
    end
  end

  always_comb begin
    taken = (take > stored_count) ? stored_count : take;
    write_pointer_next      = write_pointer;
    nalu_base_next          = nalu_base;
    stored_count_next       = stored_count - taken;
    nalu_len_next           = nalu_len;
    zero_run_next           = zero_run;
    inside_nalu_next        = inside_nalu;
    first_nalu_pending_next = first_nalu_pending;
    frame_time_next         = frame_open ? frame_time : timestamp;
    byte_we    = 1'b0;
    byte_waddr = write_pointer;
    byte_wdata = data_byte;
    desc_we    = 1'b0;
    desc_waddr = desc_wr_idx;
    desc_wdata = '{stamp: frame_time_next, len: len_b, first: first_nalu_pending, last: 1'b0};
    wp_close   = write_pointer;
    sc_close   = stored_count;

    if (push_fire && !reject) begin
      if (sc_hit) begin
        // close the running NALU, then reserve a descriptor slot for the next
        if (inside_nalu) begin
          if (keep) begin
            desc_we  = 1'b1;
            wp_close = addr_sub(write_pointer, AW'(trim));
            sc_close = stored_count - trim;
            first_nalu_pending_next = 1'b0;
          end else begin
            wp_close = nalu_base;
            sc_close = stored_count - nalu_len - count_t'(DESC_BYTES);
          end
        end
        nalu_base_next     = wp_close;
        write_pointer_next = addr_add(wp_close, AW'(DESC_BYTES));
        stored_count_next  = sc_close + count_t'(DESC_BYTES);
        nalu_len_next      = '0;
        inside_nalu_next   = 1'b1;
        zero_run_next      = '0;
      end else begin
        if (inside_nalu) begin
          byte_we            = 1'b1;
          write_pointer_next = addr_add(write_pointer, AW'(1));
          stored_count_next  = stored_count + count_t'(1);
          nalu_len_next      = nalu_len + count_t'(1);
        end
        if (data_byte == 8'h00) begin
          zero_run_next = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
        end else begin
          zero_run_next = '0;
        end
      end
      if (end_of_frame) begin
        if (inside_nalu_next) begin
          if (nalu_len_next > count_t'(1)) begin
            desc_we    = 1'b1;
            desc_wdata = '{stamp: frame_time_next, len: nalu_len_next,
                           first: first_nalu_pending_next, last: 1'b1};
          end else begin
            write_pointer_next = nalu_base_next;
            stored_count_next  = stored_count_next - nalu_len_next - count_t'(DESC_BYTES);
          end
        end
        inside_nalu_next        = 1'b0;
        zero_run_next           = '0;
        first_nalu_pending_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer      <= '0;
      nalu_base          <= '0;
      stored_count       <= '0;
      nalu_len           <= '0;
      zero_run           <= '0;
      inside_nalu        <= 1'b0;
      first_nalu_pending <= 1'b1;
      frame_open         <= 1'b0;
      frame_time         <= '0;
      desc_wr_idx        <= '0;
    end else begin
      write_pointer      <= write_pointer_next;
      nalu_base          <= nalu_base_next;
      stored_count       <= stored_count_next;
      nalu_len           <= nalu_len_next;
      zero_run           <= zero_run_next;
      inside_nalu        <= inside_nalu_next;
      first_nalu_pending <= first_nalu_pending_next;
      if (push_fire && !reject) begin
        frame_time <= frame_time_next;
        frame_open <= !end_of_frame;
      end
      if (desc_we) begin
        desc_wr_idx <= (desc_wr_idx == DW'(DESC_DEPTH - 1)) ? '0 : desc_wr_idx + DW'(1);
      end
    end
  end

endmodule

FILE: hdl/hrtp_reader.sv
module hrtp_reader (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pull_fire,
  input  logic                 commit,
  input  hrtp_pkg::desc_t      desc_rdata,
  output logic                 pull_wait,
  output hrtp_pkg::pull_info_t info,
  output logic                 byte_re,
  output hrtp_pkg::addr_t      byte_raddr,
  output hrtp_pkg::count_t     take,
  output logic                 desc_re,
  output hrtp_pkg::desc_idx_t  desc_raddr
);
  import hrtp_pkg::*;

  logic        rd_active, rd_big, rd_first, rd_last, frag_last;
  count_t      rd_rem;
  logic [31:0] rd_time;
  fu_phase_t   fu_phase, fu_phase_next;
  logic [15:0] fragment_index;
  logic [PRW-1:0] packet_remaining;
  addr_t       read_pointer;
  desc_cnt_t   ready_count, desc_avail;
  desc_idx_t   desc_rd_idx;
  logic        head_valid, fetch_pending;
  desc_t       head;

  logic        empty, activate, pop, fetch, done;
  logic        e_big, e_first, e_last, n_fl;
  count_t      e_rem, rem_next;
  logic [31:0] e_time;
  addr_t       rp_desc, e_rp, rp_next;
  logic [15:0] e_fi;
  logic [PRW-1:0] e_pr, pr1, pr2;
  fu_phase_t   e_phase;
  count_t      take0;
  logic        big_new;

  always_comb begin
    empty     = !rd_active && (ready_count == '0);
    activate  = !rd_active;
    pull_wait = activate && !empty && !head_valid;
    big_new   = head.len > count_t'(BIG_LIMIT);
    rp_desc   = addr_add(read_pointer, AW'(DESC_BYTES));

    e_big   = activate ? big_new : rd_big;
    e_first = activate ? head.first : rd_first;
    e_last  = activate ? head.last : rd_last;
    e_time  = activate ? head.stamp : rd_time;
    if (activate) begin
      e_rem = big_new ? head.len - count_t'(1) : head.len;
      e_rp  = big_new ? addr_add(rp_desc, AW'(1)) : rp_desc;
      take0 = big_new ? count_t'(DESC_BYTES + 1) : count_t'(DESC_BYTES);
      e_fi  = '0;
      e_pr  = '0;
    end else begin
      e_rem = rd_rem;
      e_rp  = read_pointer;
      take0 = '0;
      e_fi  = fragment_index;
      e_pr  = packet_remaining;
    end
    e_phase = fu_phase;
    n_fl    = frag_last;
    pr1     = e_pr;
    if (e_pr == '0) begin
      if (e_big) begin
        n_fl    = e_rem <= count_t'(FU_CHUNK);
        pr1     = n_fl ? PRW'(e_rem) + PRW'(2) : PRW'(FU_CHUNK + 2);
        e_phase = PH_IND;
      end else begin
        pr1 = PRW'(e_rem);
      end
    end

    info           = '0;
    info.status    = empty ? ST_EMPTY : ST_BYTE;
    info.kind      = BK_DATA;
    info.pkt_start = e_pr == '0;
    info.ptime     = e_time;
    fu_phase_next  = e_phase;
    rp_next        = e_rp;
    rem_next       = e_rem;
    take           = '0;
    byte_re        = 1'b0;
    byte_raddr     = e_rp;
    if (e_big && e_phase == PH_IND) begin
      info.kind     = activate ? BK_IND_RAM : BK_IND_REG;
      fu_phase_next = PH_HDR;
      byte_raddr    = rp_desc;
      byte_re       = pull_fire && activate && !empty;
    end else if (e_big && e_phase == PH_HDR) begin
      info.kind     = BK_HDR;
      info.fu_s     = e_fi == '0;
      info.fu_e     = n_fl;
      fu_phase_next = PH_DATA;
    end else begin
      rp_next  = addr_add(e_rp, AW'(1));
      rem_next = (e_rem != '0) ? e_rem - count_t'(1) : e_rem;
      take     = count_t'(1);
      byte_re  = pull_fire && !empty;
    end
    // release store bytes only on an accepted pull
    take          = (pull_fire && !empty) ? take + take0 : '0;
    pr2           = pr1 - PRW'(1);
    info.pkt_end  = pr2 == '0;
    info.fr_first = e_big ? (e_first && e_fi == '0) : e_first;
    info.fr_last  = e_big ? (e_last && n_fl) : e_last;
    if (empty) begin
      info        = '0;
      info.status = ST_EMPTY;
    end
    done = info.pkt_end && (!e_big || n_fl);

    pop        = pull_fire && activate && !empty;
    fetch      = !fetch_pending && (!head_valid || pop) && (desc_avail != '0);
    desc_re    = fetch;
    desc_raddr = desc_rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active        <= 1'b0;
      rd_big           <= 1'b0;
      rd_first         <= 1'b0;
      rd_last          <= 1'b0;
      frag_last        <= 1'b0;
      rd_rem           <= '0;
      rd_time          <= '0;
      fu_phase         <= PH_IND;
      fragment_index   <= '0;
      packet_remaining <= '0;
      read_pointer     <= '0;
      ready_count      <= '0;
      desc_avail       <= '0;
      desc_rd_idx      <= '0;
      head_valid       <= 1'b0;
      fetch_pending    <= 1'b0;
    end else begin
      if (pull_fire && !empty) begin
        rd_active        <= !done;
        rd_big           <= e_big;
        rd_first         <= e_first;
        rd_last          <= e_last;
        rd_time          <= e_time;
        frag_last        <= n_fl;
        rd_rem           <= rem_next;
        fu_phase         <= fu_phase_next;
        packet_remaining <= pr2;
        read_pointer     <= rp_next;
        fragment_index   <= (info.pkt_end && e_big) ? e_fi + 16'd1 : e_fi;
      end
      ready_count <= ready_count + DCW'(commit) - DCW'(pull_fire && !empty && done);
      desc_avail  <= desc_avail + DCW'(commit) - DCW'(fetch);
      if (fetch) begin
        desc_rd_idx <= (desc_rd_idx == DW'(DESC_DEPTH - 1)) ? '0 : desc_rd_idx + DW'(1);
      end
      fetch_pending <= fetch;
      if (fetch_pending) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_pending) begin
      head <= desc_rdata;
    end
  end

endmodule

FILE: hdl/h264_annexb_rtp_packetizer_top.sv
// Channel  Handshake               Beat contents
// in       in_valid / in_ready     op, data_byte, end_of_frame, timestamp
// out      out_valid / out_ready   status, payload_byte, packet_start, packet_end,
//                                  marker, frame_first, frame_last, packet_time
//
// One beat in per cycle while in_ready is high, one result beat out per input beat.
// In to out, a beat passes the byte store read (read stage), then the output register.
// A pull that opens a queued NALU waits while its descriptor
// is still being fetched from the descriptor memory.
// rst is synchronous; no clearing pass, the store has no reset contents.
// A stalled out channel holds the output register, then the read stage, then in_ready.
module h264_annexb_rtp_packetizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic        end_of_frame,
  input  logic [31:0] timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  payload_byte,
  output logic        packet_start,
  output logic        packet_end,
  output logic        marker,
  output logic        frame_first,
  output logic        frame_last,
  output logic [31:0] packet_time
);
  import hrtp_pkg::*;

  logic       push_fire, pull_fire, fire, is_pull;
  logic       reject, pull_wait;
  logic       byte_we, byte_re, desc_we, desc_re;
  addr_t      byte_waddr, byte_raddr;
  logic [7:0] byte_wdata, byte_rdata;
  desc_idx_t  desc_waddr, desc_raddr;
  desc_t      desc_wdata, desc_rdata;
  logic [$bits(desc_t)-1:0] desc_rbits;
  count_t     take;
  pull_info_t pull_info, push_info, s1_info;
  logic       s1_valid, s1_move;
  logic [7:0] nalu_head, out_byte;

  // Read stage advances when the output register is free or being drained.
  assign is_pull   = op == OP_PULL;
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = (!s1_valid || s1_move) && !(is_pull && pull_wait);
  assign fire      = in_valid && in_ready;
  assign push_fire = fire && !is_pull;
  assign pull_fire = fire && is_pull;

  hrtp_writer u_writer (
    .clk, .rst, .push_fire, .data_byte, .end_of_frame, .timestamp, .take,
    .reject, .byte_we, .byte_waddr, .byte_wdata, .desc_we, .desc_waddr, .desc_wdata
  );

  hrtp_reader u_reader (
    .clk, .rst, .pull_fire, .commit(desc_we), .desc_rdata, .pull_wait,
    .info(pull_info), .byte_re, .byte_raddr, .take, .desc_re, .desc_raddr
  );

  hrtp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_byte_store (
    .clk, .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
    .re(byte_re), .raddr(byte_raddr), .rdata(byte_rdata)
  );

  hrtp_ram #(.WIDTH($bits(desc_t)), .DEPTH(DESC_DEPTH)) u_desc_store (
    .clk, .we(desc_we), .waddr(desc_waddr), .wdata(desc_wdata),
    .re(desc_re), .raddr(desc_raddr), .rdata(desc_rbits)
  );
  assign desc_rdata = desc_t'(desc_rbits);

  always_comb begin
    push_info        = '0;
    push_info.status = reject ? ST_FULL : ST_PUSH_OK;
  end

  // Build the payload byte from the store read or the held NALU header.
  always_comb begin
    unique case (s1_info.kind)
      BK_DATA:    out_byte = byte_rdata;
      BK_IND_RAM: out_byte = FU_A_TYPE | (byte_rdata & NRI_MASK);
      BK_IND_REG: out_byte = FU_A_TYPE | (nalu_head & NRI_MASK);
      BK_HDR:     out_byte = (nalu_head & NAL_TYPE_MASK) | (s1_info.fu_s ? FU_START : 8'h00)
                             | (s1_info.fu_e ? FU_END : 8'h00);
      default:    out_byte = byte_rdata;
    endcase
    if (s1_info.status != ST_BYTE) begin
      out_byte = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_info <= is_pull ? pull_info : push_info;
    end
    if (s1_move) begin
      status       <= s1_info.status;
      payload_byte <= out_byte;
      packet_start <= s1_info.pkt_start;
      packet_end   <= s1_info.pkt_end;
      marker       <= s1_info.fr_last;
      frame_first  <= s1_info.fr_first;
      frame_last   <= s1_info.fr_last;
      packet_time  <= s1_info.ptime;
      if (s1_info.status == ST_BYTE && s1_info.kind == BK_IND_RAM) begin
        nalu_head <= byte_rdata;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_store_collision: assert property (@(posedge clk) disable iff (rst)
    !(byte_we && byte_re))
    else $error("byte store read and write in the same cycle");

  a_indicator_starts_packet: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_info.status == ST_BYTE
     && (s1_info.kind == BK_IND_RAM || s1_info.kind == BK_IND_REG)) |-> s1_info.pkt_start)
    else $error("FU indicator not on a packet start");

  a_header_mid_packet: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_info.status == ST_BYTE && s1_info.kind == BK_HDR)
    |-> (!s1_info.pkt_start && !s1_info.pkt_end))
    else $error("FU header on a packet edge");

  a_wait_blocks_pull: assert property (@(posedge clk) disable iff (rst)
    pull_wait |-> !pull_fire)
    else $error("pull accepted without its descriptor");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
  import hrtp_pkg::*;

  // Generous cycle limit: about 15k beats, each possibly waiting out a long
  // sender gap and a long receiver stall.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        end_of_frame;
  logic [31:0] timestamp;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [7:0]  payload_byte;
  logic        packet_start;
  logic        packet_end;
  logic        marker;
  logic        frame_first;
  logic        frame_last;
  logic [31:0] packet_time;

  h264_annexb_rtp_packetizer_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .data_byte(data_byte), .end_of_frame(end_of_frame), .timestamp(timestamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .payload_byte(payload_byte),
    .packet_start(packet_start), .packet_end(packet_end), .marker(marker),
    .frame_first(frame_first), .frame_last(frame_last), .packet_time(packet_time)
  );

  // One expected output beat.
  typedef struct packed {
    status_t     st;
    logic [7:0]  pb;
    logic        ps;
    logic        pe;
    logic        mk;
    logic        ff;
    logic        fl;
    logic [31:0] pt;
  } payload_beat_t;

  payload_beat_t expected_beats[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned full_rejects;
  int unsigned bytes_pulled;
  bit          in_gaps_on;
  bit          out_stalls_on;

  // ---------------------------------------------------------------------
  // Packetizer predictor: circular store of descriptors plus NALU bytes,
  // start code hunter on the write side, FU-A splitter on the read side.
  // ---------------------------------------------------------------------
  logic [7:0]  nal_store [STORE_DEPTH];
  int unsigned wr_ptr, rd_ptr, used_bytes, zeros_seen;
  int unsigned open_base, open_len, queued_nalus;
  int unsigned rem_bytes, frag_idx, pkt_left, head_byte, out_time, fu_step;
  bit          in_unit, pending_first, frame_active;
  bit          reading, reading_big, read_first, read_last, last_frag;
  logic [31:0] latched_time;

  function automatic int unsigned wrap_add(int unsigned p, int unsigned n);
    p += n;
    while (p >= STORE_DEPTH) p -= STORE_DEPTH;
    return p;
  endfunction

  function automatic logic [7:0] pop_store();
    logic [7:0] v;
    v = nal_store[rd_ptr];
    rd_ptr = wrap_add(rd_ptr, 1);
    if (used_bytes > 0) used_bytes--;
    return v;
  endfunction

  function automatic logic [7:0] frame_time_byte(int i);
    return latched_time[8*i +: 8];
  endfunction

  // Write the descriptor in front of the open NALU and queue it.
  function automatic void queue_unit(int unsigned len, bit last);
    logic [7:0]  d [6];
    int unsigned p;
    d[0] = frame_time_byte(0);
    d[1] = frame_time_byte(1);
    d[2] = frame_time_byte(2);
    d[3] = frame_time_byte(3);
    d[4] = len[7:0];
    d[5] = {2'b00, pending_first, last, len[11:8]};
    p = open_base;
    for (int i = 0; i < DESC_BYTES; i++) begin
      nal_store[p] = d[i];
      p = wrap_add(p, 1);
    end
    wr_ptr = wrap_add(open_base, DESC_BYTES + len);
    used_bytes -= open_len - len;
    queued_nalus++;
    pending_first = 0;
  endfunction

  function automatic void drop_unit();
    wr_ptr = open_base;
    used_bytes -= open_len + DESC_BYTES;
  endfunction

  function automatic payload_beat_t predict_push(logic [7:0] b, logic eof, logic [31:0] ts);
    payload_beat_t r;
    bit          start_code;
    bit          keep;
    int unsigned len;
    int unsigned freed;
    r = '0;
    start_code = zeros_seen >= 2 && b == 8'd1;
    keep = 0;
    len = 0;
    freed = 0;
    if (start_code) begin
      if (in_unit) begin
        len = open_len >= 2 ? open_len - 2 : 0;
        if (len > 1 && zeros_seen == 3) len--;
        keep = len > 1;
        freed = keep ? open_len - len : open_len + DESC_BYTES;
      end
      if (STORE_DEPTH - (used_bytes - freed) < DESC_BYTES) begin
        r.st = ST_FULL;
        return r;
      end
    end else if (in_unit && used_bytes >= STORE_DEPTH) begin
      r.st = ST_FULL;
      return r;
    end
    if (!frame_active) begin
      latched_time = ts;
      frame_active = 1;
    end
    if (start_code) begin
      if (in_unit) begin
        if (keep) queue_unit(len, 0);
        else drop_unit();
      end
      open_base = wr_ptr;
      wr_ptr = wrap_add(wr_ptr, DESC_BYTES);
      used_bytes += DESC_BYTES;
      open_len = 0;
      in_unit = 1;
      zeros_seen = 0;
    end else begin
      if (in_unit) begin
        nal_store[wr_ptr] = b;
        wr_ptr = wrap_add(wr_ptr, 1);
        used_bytes++;
        open_len++;
      end
      zeros_seen = (b == 8'd0) ? (zeros_seen < 3 ? zeros_seen + 1 : 3) : 0;
    end
    if (eof) begin
      if (in_unit) begin
        if (open_len > 1) queue_unit(open_len, 1);
        else drop_unit();
      end
      in_unit = 0;
      zeros_seen = 0;
      pending_first = 1;
      frame_active = 0;
    end
    r.st = ST_PUSH_OK;
    return r;
  endfunction

  function automatic payload_beat_t predict_pull();
    payload_beat_t r;
    logic [31:0]   t;
    logic [7:0]    lo;
    logic [7:0]    hi;
    logic [7:0]    v;
    bit            pkt_first;
    bit            pkt_last;
    bit            ff;
    bit            fl;
    r = '0;
    if (!reading) begin
      if (queued_nalus == 0) begin
        r.st = ST_EMPTY;
        return r;
      end
      t = '0;
      for (int i = 0; i < 4; i++) t |= 32'(pop_store()) << (8 * i);
      lo = pop_store();
      hi = pop_store();
      out_time = t;
      rem_bytes = 32'({hi[3:0], lo});
      read_first = hi[5];
      read_last = hi[4];
      reading_big = rem_bytes + HEADER_BYTES > PACKET_BYTES;
      frag_idx = 0;
      pkt_left = 0;
      if (reading_big && rem_bytes > 0) begin
        head_byte = 32'(pop_store());
        rem_bytes--;
      end
      reading = 1;
    end
    pkt_first = pkt_left == 0;
    if (pkt_first) begin
      if (reading_big) begin
        last_frag = rem_bytes <= FU_CHUNK;
        pkt_left = (last_frag ? rem_bytes : FU_CHUNK) + 2;
        fu_step = 0;
      end else begin
        pkt_left = rem_bytes > 0 ? rem_bytes : 1;
      end
    end
    if (reading_big && fu_step == 0) begin
      v = FU_A_TYPE | (8'(head_byte) & NRI_MASK);
      fu_step = 1;
    end else if (reading_big && fu_step == 1) begin
      v = (8'(head_byte) & NAL_TYPE_MASK) | (frag_idx == 0 ? FU_START : 8'h00) |
          (last_frag ? FU_END : 8'h00);
      fu_step = 2;
    end else begin
      v = pop_store();
      if (rem_bytes > 0) rem_bytes--;
    end
    pkt_left--;
    pkt_last = pkt_left == 0;
    if (reading_big) begin
      ff = read_first && frag_idx == 0;
      fl = read_last && last_frag;
    end else begin
      ff = read_first;
      fl = read_last;
    end
    if (pkt_last) begin
      if (reading_big) frag_idx = (frag_idx + 1) & 16'hFFFF;
      if (!reading_big || last_frag) begin
        reading = 0;
        queued_nalus--;
      end
    end
    r.st = ST_BYTE;
    r.pb = v;
    r.ps = pkt_first;
    r.pe = pkt_last;
    r.mk = fl;
    r.ff = ff;
    r.fl = fl;
    r.pt = out_time;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, cycle limit, idling
  // ---------------------------------------------------------------------
  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_len(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: alternate ready bursts with stalls of random length.
  initial begin : sink_pacing
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      n = gap_len(out_stalls_on);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
             cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    payload_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, status", status, 0);
      end else begin
        e = expected_beats.pop_front();
        beats_checked++;
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (payload_byte !== e.pb) report_mismatch("payload_byte", payload_byte, e.pb);
        if (packet_start !== e.ps) report_mismatch("packet_start", packet_start, e.ps);
        if (packet_end !== e.pe) report_mismatch("packet_end", packet_end, e.pe);
        if (marker !== e.mk) report_mismatch("marker", marker, e.mk);
        if (frame_first !== e.ff) report_mismatch("frame_first", frame_first, e.ff);
        if (frame_last !== e.fl) report_mismatch("frame_last", frame_last, e.fl);
        if (packet_time !== e.pt) report_mismatch("packet_time", packet_time, e.pt);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving: called at a falling edge, returns at the falling edge after
  // the beat is taken with valid still high so the next beat can follow.
  // ---------------------------------------------------------------------
  task automatic send_beat(op_t o, logic [7:0] b, logic eof, logic [31:0] ts);
    int n;
    payload_beat_t e;
    n = gap_len(in_gaps_on);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    data_byte    <= b;
    end_of_frame <= eof;
    timestamp    <= ts;
    do @(posedge clk); while (!in_ready);
    e = (o == OP_PUSH) ? predict_push(b, eof, ts) : predict_pull();
    expected_beats.push_back(e);
    beats_sent++;
    if (e.st == ST_FULL) full_rejects++;
    if (e.st == ST_BYTE) bytes_pulled++;
    @(negedge clk);
  endtask

  task automatic pull_byte();
    send_beat(OP_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic idle_in();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain every queued NALU, then one more pull to see the empty answer.
  task automatic drain_store();
    while (queued_nalus > 0 || reading) pull_byte();
    pull_byte();
  endtask

  // Push one frame; the first byte carries the frame time, the rest carry
  // noise that must not be latched. Pulls are mixed in at pull_pct.
  task automatic push_frame_bytes(logic [7:0] fb[$], logic [31:0] ts, int pull_pct);
    foreach (fb[k]) begin
      send_beat(OP_PUSH, fb[k], k == fb.size() - 1, k == 0 ? ts : $urandom);
      while ($urandom_range(0, 99) < pull_pct) pull_byte();
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 1);
    if (r < 85) return $urandom_range(2, 60);
    if (r < 97) return $urandom_range(61, 400);
    return $urandom_range(1100, 1300);
  endfunction

  // Build and push a frame of NALUs. hi_len of zero picks random lengths and
  // allows noise frames and odd endings.
  task automatic send_frame(int units, int pull_pct, int lo_len, int hi_len);
    logic [7:0]  fb[$];
    logic [31:0] ts;
    int          len;
    fb = {};
    if (hi_len == 0 && $urandom_range(0, 9) == 0) begin
      // broken frame: raw bytes, zero-heavy so partial start codes appear
      repeat ($urandom_range(1, 20)) fb.push_back($urandom_range(0, 3) == 0 ?
                                                   8'($urandom_range(0, 255)) :
                                                   8'($urandom_range(0, 1)));
    end else begin
      // drop leading junk before the first start code
      if (hi_len == 0) repeat ($urandom_range(0, 2)) fb.push_back(8'($urandom_range(1, 255)));
      repeat (units) begin
        if ($urandom_range(0, 3) == 0) fb.push_back(8'h00);
        fb.push_back(8'h00);
        fb.push_back(8'h00);
        fb.push_back(8'h01);
        len = (hi_len > 0) ? $urandom_range(lo_len, hi_len) : pick_len();
        repeat (len) fb.push_back(8'($urandom_range(0, 255)));
        if (hi_len == 0 && $urandom_range(0, 4) == 0) fb.push_back(8'h00);
      end
      // start code on the final byte
      if (hi_len == 0 && $urandom_range(0, 19) == 0) begin
        fb.push_back(8'h00);
        fb.push_back(8'h00);
        fb.push_back(8'h01);
      end
    end
    case ($urandom_range(0, 3))
      0:       ts = 32'h0000_0000;
      1:       ts = 32'hFFFF_FFFF;
      default: ts = $urandom;
    endcase
    push_frame_bytes(fb, ts, pull_pct);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    // empty pull, junk before start, four-byte start code trimming one zero
    pull_byte();
    push_frame_bytes('{8'h55, 8'h00, 8'h00, 8'h01, 8'hE5, 8'hFF, 8'h00, 8'h00, 8'h00,
                       8'h01, 8'h41, 8'h00}, 32'hFFFF_FFFF, 0);
    drain_store();
    // one-byte final NALU is skipped: no marker in this frame
    push_frame_bytes('{8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h00, 8'h01, 8'h09},
                     32'h0000_0000, 0);
    // start code as the last byte of a frame
    push_frame_bytes('{8'h00, 8'h00, 8'h01, 8'h61, 8'h80, 8'h00, 8'h00, 8'h01},
                     32'h1234_5678, 30);
    drain_store();
    idle_in();
  endtask

  task automatic test_random_frames(int unsigned n_items);
    int unsigned stop_at;
    stop_at = beats_sent + n_items;
    while (beats_sent < stop_at) begin
      // switch idling off for some stretches
      in_gaps_on    = $urandom_range(0, 4) != 0;
      out_stalls_on = $urandom_range(0, 4) != 0;
      send_frame($urandom_range(1, 4), $urandom_range(30, 70), 0, 0);
      if ($urandom_range(0, 3) == 0) drain_store();
    end
    in_gaps_on    = 1;
    out_stalls_on = 1;
    drain_store();
    idle_in();
  endtask

  // Lengths on both sides of the single packet limit.
  task automatic test_fragmentation();
    send_frame(1, 50, BIG_LIMIT, BIG_LIMIT);
    send_frame(1, 50, BIG_LIMIT + 1, BIG_LIMIT + 1);
    drain_store();
    idle_in();
  endtask

  // Push without pulling until the store rejects, then drain.
  task automatic test_store_full();
    int unsigned seen;
    int          guard;
    seen = full_rejects;
    guard = 0;
    while (full_rejects == seen && guard < 40) begin
      send_frame(2, 0, 50, 300);
      guard++;
    end
    repeat (20) send_beat(OP_PUSH, 8'h00, 1'b0, $urandom);
    drain_store();
    idle_in();
  endtask

  // A NALU larger than the store: data pushes keep getting rejected.
  task automatic test_oversized_nalu();
    send_frame(1, 0, STORE_DEPTH + 50, STORE_DEPTH + 50);
    drain_store();
    idle_in();
  endtask

  initial begin : main
    int guard;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_PUSH;
    data_byte = 8'h00;
    end_of_frame = 1'b0;
    timestamp = 32'h0;
    in_gaps_on = 1;
    out_stalls_on = 1;
    cycle_count = 0;
    error_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    full_rejects = 0;
    bytes_pulled = 0;
    // predictor reset state
    wr_ptr = 0; rd_ptr = 0; used_bytes = 0; zeros_seen = 0;
    open_base = 0; open_len = 0; queued_nalus = 0;
    rem_bytes = 0; frag_idx = 0; pkt_left = 0; head_byte = 0; out_time = 0; fu_step = 0;
    in_unit = 0; pending_first = 1; frame_active = 0; latched_time = 0;
    reading = 0; reading_big = 0; read_first = 0; read_last = 0; last_frag = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_frames(2000);
    test_fragmentation();
    test_store_full();
    test_oversized_nalu();

    // wait for the last results, then let the pipeline settle
    guard = 0;
    while (expected_beats.size() > 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    if (expected_beats.size() != 0)
      report_mismatch("beats never delivered", expected_beats.size(), 0);

    $display("covered %0d beats (%0d checked): %0d payload bytes pulled, %0d full rejects",
             beats_sent, beats_checked, bytes_pulled, full_rejects);
    $display("directed start code cases, random frames, FU-A splits, store full, oversize");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
